### rtl/amfp_pkg.sv
// Shared types and constants for the advertising-data manufacturer-structure parser.
// No dependencies; imported by amfp_parser and adv_manufacturer_field_parser.
`timescale 1ns / 1ps

package amfp_pkg;

    // Depth of the payload buffer, in bytes.
    localparam int PAYLOAD_MAX = 18;
    localparam int PAY_IDX_W   = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    // Outcome of one advertising-data run.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_OVERRUN  = 3'd2,
        ST_HEADER   = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_FIELDS   = 3'd5,
        ST_NOTFOUND = 3'd6
    } t_status;

    // Final status and captured packet header of one run.
    typedef struct packed {
        t_status     status;
        logic [7:0]  chan;
        logic [15:0] seq_number;
        logic [7:0]  frag_position;
        logic [7:0]  frag_total;
        logic [7:0]  pay_length;
    } t_summary;

endpackage

### rtl/amfp_parser.sv
// Length-type-value walker, manufacturer-structure checker and payload buffer.
// Depends on amfp_pkg; instantiated by adv_manufacturer_field_parser.
`timescale 1ns / 1ps

module amfp_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [7:0]                    i_byte,
    input  logic                          i_last,
    input  logic [15:0]                   i_invalid_seq,
    input  logic [15:0]                   i_exp_company,
    input  logic [7:0]                    i_exp_version,
    output amfp_pkg::t_summary            o_summary,
    input  logic [amfp_pkg::PAY_IDX_W-1:0] i_rd_idx,
    output logic [7:0]                    o_rd_byte
);
    import amfp_pkg::*;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_TYPE,
        PH_SKIP,
        PH_MFR,
        PH_DONE
    } t_phase;

    localparam logic [7:0] MFR_TYPE      = 8'hFF;
    localparam logic [7:0] MFR_HDR_LEN   = 8'd12;
    localparam logic [7:0] CHAR_E        = 8'h45;
    localparam logic [7:0] CHAR_R        = 8'h52;
    localparam logic [7:0] PAY_MAX8      = 8'(PAYLOAD_MAX);

    // Byte positions inside the manufacturer structure (type byte is position 1).
    localparam logic [7:0] POS_CO_LO     = 8'd2;
    localparam logic [7:0] POS_CO_HI     = 8'd3;
    localparam logic [7:0] POS_MAGIC_E   = 8'd4;
    localparam logic [7:0] POS_MAGIC_R   = 8'd5;
    localparam logic [7:0] POS_VERSION   = 8'd6;
    localparam logic [7:0] POS_CHAN      = 8'd7;
    localparam logic [7:0] POS_SEQ_LO    = 8'd8;
    localparam logic [7:0] POS_SEQ_HI    = 8'd9;
    localparam logic [7:0] POS_FRAG_POS  = 8'd10;
    localparam logic [7:0] POS_FRAG_TOT  = 8'd11;
    localparam logic [7:0] POS_PAY_LEN   = 8'd12;
    localparam logic [7:0] POS_PAY_FIRST = 8'd13;

    t_phase      r_phase,     n_phase;
    logic [7:0]  r_left,      n_left;
    logic [7:0]  r_pos,       n_pos;
    t_status     r_verdict,   n_verdict;
    logic [7:0]  r_chan,      n_chan;
    logic [15:0] r_seq,       n_seq;
    logic [7:0]  r_frag_pos,  n_frag_pos;
    logic [7:0]  r_frag_tot,  n_frag_tot;
    logic [7:0]  r_pay_len,   n_pay_len;

    logic [7:0]  pos_inc;
    logic [7:0]  left_dec;
    logic [7:0]  wr_off;
    logic        wr_en;
    logic        mfr_bad;
    logic        run_closed;

    logic [7:0]  r_store [PAYLOAD_MAX];
    logic [7:0]  r_rd_byte;

    // Next state for one byte of advertising data.
    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_pos      = r_pos;
        n_verdict  = r_verdict;
        n_chan     = r_chan;
        n_seq      = r_seq;
        n_frag_pos = r_frag_pos;
        n_frag_tot = r_frag_tot;
        n_pay_len  = r_pay_len;
        mfr_bad    = 1'b0;
        pos_inc    = r_pos + 8'd1;
        left_dec   = r_left - 8'd1;

        case (r_phase)
            PH_LEN: begin
                if (i_byte == 8'd0) begin
                    n_verdict = ST_ZERO;
                    n_phase   = PH_DONE;
                end else begin
                    n_left  = i_byte;
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_pos  = 8'd1;
                n_left = left_dec;
                if (i_byte == MFR_TYPE) begin
                    n_verdict = (r_left < MFR_HDR_LEN) ? ST_HEADER : ST_OK;
                    n_phase   = (left_dec == 8'd0) ? PH_DONE : PH_MFR;
                end else begin
                    n_phase   = (left_dec == 8'd0) ? PH_LEN : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_pos  = pos_inc;
                n_left = left_dec;
                if (left_dec == 8'd0) begin
                    n_phase = PH_LEN;
                end
            end
            PH_MFR: begin
                n_pos  = pos_inc;
                n_left = left_dec;
                case (pos_inc)
                    POS_CO_LO:    mfr_bad = (i_byte != i_exp_company[7:0]);
                    POS_CO_HI:    mfr_bad = (i_byte != i_exp_company[15:8]);
                    POS_MAGIC_E:  mfr_bad = (i_byte != CHAR_E);
                    POS_MAGIC_R:  mfr_bad = (i_byte != CHAR_R);
                    POS_VERSION:  mfr_bad = (i_byte != i_exp_version);
                    POS_CHAN:     n_chan = i_byte;
                    POS_SEQ_LO:   n_seq = {r_seq[15:8], i_byte};
                    POS_SEQ_HI:   n_seq = {i_byte, r_seq[7:0]};
                    POS_FRAG_POS: n_frag_pos = i_byte;
                    POS_FRAG_TOT: n_frag_tot = i_byte;
                    POS_PAY_LEN: begin
                        // The remaining structure length must match the payload length.
                        n_pay_len = i_byte;
                        if (r_verdict == ST_OK) begin
                            if (i_byte > PAY_MAX8 || left_dec != i_byte) begin
                                n_verdict = ST_LENGTH;
                            end else if (r_chan == 8'd0 || r_seq == i_invalid_seq ||
                                         r_frag_tot == 8'd0 || r_frag_pos >= r_frag_tot) begin
                                n_verdict = ST_FIELDS;
                            end
                        end
                    end
                    default: ;
                endcase
                if (mfr_bad && r_verdict == ST_OK) begin
                    n_verdict = ST_HEADER;
                end
                if (left_dec == 8'd0) begin
                    n_phase = PH_DONE;
                end
            end
            default: ;
        endcase
    end

    // Payload bytes land in the buffer as they pass.
    assign wr_off = pos_inc - POS_PAY_FIRST;
    assign wr_en  = (r_phase == PH_MFR) && (pos_inc >= POS_PAY_FIRST) && (wr_off < PAY_MAX8);

    // Status of the run if this byte is the last one.
    assign run_closed = (n_phase == PH_LEN) || (n_phase == PH_DONE);

    always_comb begin
        o_summary.status        = run_closed ? n_verdict : ST_OVERRUN;
        o_summary.chan          = 8'd0;
        o_summary.seq_number    = 16'd0;
        o_summary.frag_position = 8'd0;
        o_summary.frag_total    = 8'd0;
        o_summary.pay_length    = 8'd0;
        if (o_summary.status == ST_OK) begin
            o_summary.chan          = n_chan;
            o_summary.seq_number    = n_seq;
            o_summary.frag_position = n_frag_pos;
            o_summary.frag_total    = n_frag_tot;
            o_summary.pay_length    = n_pay_len;
        end
    end

    // Parser state; the last byte of a run rearms it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase    <= PH_LEN;
            r_left     <= 8'd0;
            r_pos      <= 8'd0;
            r_verdict  <= ST_NOTFOUND;
            r_chan     <= 8'd0;
            r_seq      <= 16'd0;
            r_frag_pos <= 8'd0;
            r_frag_tot <= 8'd0;
            r_pay_len  <= 8'd0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_left     <= n_left;
            r_pos      <= n_pos;
            r_verdict  <= n_verdict;
            r_chan     <= n_chan;
            r_seq      <= n_seq;
            r_frag_pos <= n_frag_pos;
            r_frag_tot <= n_frag_tot;
            r_pay_len  <= n_pay_len;
        end
    end

    // Payload buffer with a registered read port; the caller presents the next index.
    always_ff @(posedge i_clk) begin
        if (i_take && wr_en) begin
            r_store[wr_off[PAY_IDX_W-1:0]] <= i_byte;
        end
        r_rd_byte <= r_store[i_rd_idx];
    end

    assign o_rd_byte = r_rd_byte;

endmodule

### rtl/adv_manufacturer_field_parser.sv
// Top level: stream ports, register port, output burst sequencer.
// Depends on amfp_pkg and amfp_parser.
//
//   Channel   Direction  Handshake          Carries
//   s stream  in         tvalid / tready    tdata: in_byte; tlast: end_of_data
//   m stream  out        tvalid / tready    tdata: result fields; tuser: is_header;
//                                           tlast: result_last
//   APB       in/out     psel/penable/...   invalid_sequence, expected_company,
//                                           expected_version
//
// Words that do not end a run are accepted each cycle while no burst is being queued.
// The word that ends a run produces a burst of one header word plus pay_length payload
// words, one per cycle from the output register while the output accepts them;
// the input is held off until the burst sequencer has queued its last word.
// Reset is synchronous and active low; it restores register defaults and rearms the parser.
`timescale 1ns / 1ps

module adv_manufacturer_field_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [2:0] status, [10:3] chan, [26:11] seq_number,
                                     // [34:27] frag_position, [42:35] frag_total,
                                     // [50:43] pay_length, [58:51] payload_out, [63:59] zero
    output logic [0:0]  o_m_tuser,   // [0] is_header
    output logic        o_m_tlast,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import amfp_pkg::*;

    localparam logic [1:0] REG_INVALID_SEQ = 2'd0;
    localparam logic [1:0] REG_EXP_COMPANY = 2'd1;
    localparam logic [1:0] REG_EXP_VERSION = 2'd2;

    logic [15:0]          r_invalid_seq;
    logic [15:0]          r_exp_company;
    logic [7:0]           r_exp_version;

    logic                 take;
    logic                 cfg_wr;
    t_summary             summary;
    logic [7:0]           rd_byte;

    logic                 r_pend;
    t_summary             r_snap;
    logic [7:0]           r_emit_left;
    logic [PAY_IDX_W-1:0] r_emit_idx;
    logic [PAY_IDX_W-1:0] n_emit_idx;
    logic                 r_out_valid;
    logic                 out_free;

    t_summary             r_out_sum;
    logic [7:0]           r_out_pay;
    logic                 r_out_hdr;
    logic                 r_out_last;

    // Register port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_seq <= 16'd0;
            r_exp_company <= 16'hFFFF;
            r_exp_version <= 8'd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_INVALID_SEQ: r_invalid_seq <= pwdata[15:0];
                REG_EXP_COMPANY: r_exp_company <= pwdata[15:0];
                REG_EXP_VERSION: r_exp_version <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_INVALID_SEQ: prdata = {16'd0, r_invalid_seq};
            REG_EXP_COMPANY: prdata = {16'd0, r_exp_company};
            REG_EXP_VERSION: prdata = {24'd0, r_exp_version};
            default:         prdata = 32'd0;
        endcase
    end

    // Input side: held off only while a burst is still being queued.
    assign o_s_tready = !r_pend && (r_emit_left == 8'd0);
    assign take       = i_s_tvalid && o_s_tready;

    amfp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_byte        (i_s_tdata),
        .i_last        (i_s_tlast),
        .i_invalid_seq (r_invalid_seq),
        .i_exp_company (r_exp_company),
        .i_exp_version (r_exp_version),
        .o_summary     (summary),
        .i_rd_idx      (n_emit_idx),
        .o_rd_byte     (rd_byte)
    );

    // Burst sequencer: header word first, then the buffered payload.
    assign out_free = !r_out_valid || i_m_tready;

    // The buffer read is registered, so it is addressed with the next payload index.
    always_comb begin
        n_emit_idx = r_emit_idx;
        if (out_free) begin
            if (r_pend) begin
                n_emit_idx = '0;
            end else if (r_emit_left != 8'd0) begin
                n_emit_idx = r_emit_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_emit_left <= 8'd0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_emit_idx <= n_emit_idx;
            if (take && i_s_tlast) begin
                r_pend <= 1'b1;
            end
            if (out_free) begin
                if (r_pend) begin
                    r_pend      <= 1'b0;
                    r_emit_left <= r_snap.pay_length;
                    r_out_valid <= 1'b1;
                end else if (r_emit_left != 8'd0) begin
                    r_emit_left <= r_emit_left - 8'd1;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (take && i_s_tlast) begin
            r_snap <= summary;
        end
        if (out_free) begin
            if (r_pend) begin
                r_out_sum  <= r_snap;
                r_out_pay  <= 8'd0;
                r_out_hdr  <= 1'b1;
                r_out_last <= (r_snap.pay_length == 8'd0);
            end else if (r_emit_left != 8'd0) begin
                r_out_pay  <= rd_byte;
                r_out_hdr  <= 1'b0;
                r_out_last <= (r_emit_left == 8'd1);
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_pay, r_out_sum.pay_length, r_out_sum.frag_total,
                         r_out_sum.frag_position, r_out_sum.seq_number, r_out_sum.chan,
                         r_out_sum.status};
    assign o_m_tuser  = r_out_hdr;
    assign o_m_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // The word that ends a run always queues a header word.
    a_last_queues_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_s_tlast |=> r_pend)
        else $error("run end did not queue a header word");

    // A pending header and an unfinished payload burst never coexist.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && r_emit_left != 8'd0))
        else $error("header pending while payload burst active");

    // Payload count never exceeds the buffer depth.
    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_left <= 8'(PAYLOAD_MAX))
        else $error("payload burst longer than buffer");

    // Payload words only follow an ok header.
    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_hdr |-> r_out_sum.status == ST_OK)
        else $error("payload word with error status");

    // A header with an error status ends its burst.
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_hdr && r_out_sum.status != ST_OK |-> r_out_last)
        else $error("error header not marked last");
`endif

endmodule
